// ----- sv/sdm_pkg.sv -----
package sdm_pkg;

  localparam int WordBits = 16;
  localparam int StageCnt = 50;
  localparam logic [WordBits-1:0] Half = 16'h8000;

  typedef enum logic [1:0] {
    PH_DIVD,
    PH_ANC,
    PH_DIVN,
    PH_ITER
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   num_bit;
  } step_ctl_t;

  typedef struct packed {
    logic                neg;
    logic                bad;
    logic [WordBits-1:0] ad;
    logic [WordBits-1:0] anc;
    logic [WordBits-1:0] q1;
    logic [WordBits-1:0] r1;
    logic [WordBits-1:0] q2;
    logic [WordBits-1:0] r2;
    logic [4:0]          cnt;
    logic                done;
  } stage_t;

  // Stage 1..16 divide 2^15 by |d|, stage 17 forms |nc|, stages 18..33
  // divide 2^15 by |nc|, the rest run one doubling step each.
  function automatic step_ctl_t stage_ctl(input int k);
    step_ctl_t c;
    c.num_bit = 1'b0;
    if (k <= 16) begin
      c.phase = PH_DIVD;
      c.num_bit = (k == 1);
    end else if (k == 17) begin
      c.phase = PH_ANC;
    end else if (k <= 33) begin
      c.phase = PH_DIVN;
      c.num_bit = (k == 18);
    end else begin
      c.phase = PH_ITER;
    end
    return c;
  endfunction

endpackage

// ----- sv/sdm_step.sv -----
module sdm_step (
  input  sdm_pkg::step_ctl_t ctl_i,
  input  sdm_pkg::stage_t    st_i,
  output sdm_pkg::stage_t    st_o
);

  logic [16:0] rem2;
  logic [16:0] rem1;
  logic [16:0] sum;
  logic [15:0] tmod;
  logic [15:0] anc_v;
  logic [15:0] q1n;
  logic [15:0] r1n;
  logic [15:0] q2n;
  logic [15:0] r2n;
  logic [15:0] delta;

  always_comb begin
    st_o  = st_i;
    rem2  = {st_i.r2, ctl_i.num_bit};
    rem1  = {st_i.r1, ctl_i.num_bit};
    sum   = {1'b0, st_i.r2} + {16'd0, st_i.neg};
    tmod  = (sum == {1'b0, st_i.ad}) ? 16'd0 : sum[15:0];
    anc_v = sdm_pkg::Half + {15'd0, st_i.neg} - 16'd1 - tmod;
    q1n   = {st_i.q1[14:0], 1'b0};
    r1n   = rem1[15:0];
    q2n   = {st_i.q2[14:0], 1'b0};
    r2n   = rem2[15:0];
    if (rem2 >= {1'b0, st_i.ad}) begin
      q2n = {st_i.q2[14:0], 1'b1};
      r2n = 16'(rem2 - {1'b0, st_i.ad});
    end
    if (rem1 >= {1'b0, st_i.anc}) begin
      q1n = {st_i.q1[14:0], 1'b1};
      r1n = 16'(rem1 - {1'b0, st_i.anc});
    end
    delta = st_i.ad - r2n;
    case (ctl_i.phase)
      sdm_pkg::PH_DIVD: begin
        st_o.q2 = q2n;
        st_o.r2 = r2n;
      end
      sdm_pkg::PH_ANC: begin
        st_o.anc = (anc_v == 16'd0) ? 16'd1 : anc_v;
        st_o.q1  = 16'd0;
        st_o.r1  = 16'd0;
      end
      sdm_pkg::PH_DIVN: begin
        st_o.q1 = q1n;
        st_o.r1 = r1n;
      end
      sdm_pkg::PH_ITER: begin
        if (!st_i.done) begin
          st_o.cnt = st_i.cnt + 5'd1;
          st_o.q1  = q1n;
          st_o.r1  = r1n;
          st_o.q2  = q2n;
          st_o.r2  = r2n;
          st_o.done = !(q1n < delta || (q1n == delta && r1n == 16'd0));
        end
      end
      default: st_o = st_i;
    endcase
  end

endmodule

// ----- sv/signed_div_magic_16.sv -----
// Throughput: one request per cycle unless the output stalls. 50-stage pipeline:
// stage 0 registers the request, stages 1..49 do one division, nc or doubling step.
// A stalled output freezes the whole pipeline.
// Reset (rst_n low, synchronous) clears all stage valid bits.
module signed_div_magic_16 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_divisor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_multiplier,
  output logic [3:0]  out_post_shift,
  output logic        out_bad_divisor
);

  localparam int Last = sdm_pkg::StageCnt - 1;

  sdm_pkg::stage_t st_r   [sdm_pkg::StageCnt];
  sdm_pkg::stage_t st_nxt [sdm_pkg::StageCnt];
  logic [sdm_pkg::StageCnt-1:0] vld_r;
  logic [sdm_pkg::StageCnt-1:0] vld_nxt;
  logic        en;
  logic [15:0] ad_in;
  logic [15:0] m_pos;

  assign en       = !vld_r[Last] || out_ready;
  assign in_ready = en;
  assign ad_in    = in_divisor[15] ? 16'(16'd0 - in_divisor) : in_divisor;

  always_comb begin
    st_nxt[0]      = '0;
    st_nxt[0].neg  = in_divisor[15];
    st_nxt[0].ad   = ad_in;
    st_nxt[0].bad  = (ad_in < 16'd2);
    vld_nxt        = {vld_r[Last-1:0], in_valid};
  end

  genvar k;
  generate
    for (k = 1; k < sdm_pkg::StageCnt; k++) begin : g_stage
      sdm_step u_step (
        .ctl_i (sdm_pkg::stage_ctl(k)),
        .st_i  (st_r[k-1]),
        .st_o  (st_nxt[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < sdm_pkg::StageCnt; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign m_pos           = st_r[Last].q2 + 16'd1;
  assign out_valid       = vld_r[Last];
  assign out_bad_divisor = st_r[Last].bad;
  assign out_multiplier  = st_r[Last].bad ? 16'd0 :
                           (st_r[Last].neg ? 16'(16'd0 - m_pos) : m_pos);
  assign out_post_shift  = st_r[Last].bad ? 4'd0 : 4'(st_r[Last].cnt - 5'd1);

  a_loop_ran : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_divisor |-> st_r[Last].cnt != 5'd0)
    else $error("doubling loop never ran");

  a_loop_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_divisor |-> st_r[Last].done || st_r[Last].cnt == 5'd16)
    else $error("doubling loop exceeded its bound");

  a_anc_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[17] && !st_r[17].bad |-> st_r[17].anc != 16'd0)
    else $error("nc magnitude is zero");

endmodule

// ----- test/tb_signed_div_magic_16.sv -----
`timescale 1ns / 1ps

module tb_signed_div_magic_16;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_divisor;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_multiplier;
  logic [3:0]  out_post_shift;
  logic        out_bad_divisor;

  typedef struct packed {
    logic [15:0] multiplier;
    logic [3:0]  post_shift;
    logic        bad;
  } magic_t;

  typedef struct {
    logic [15:0] divisor;
    logic        typed;
    magic_t      result;
  } dir_row_t;

  localparam int NumRandom = 1630;
  localparam int DrainCycles = 60;

  magic_t magic_q[$];
  int     mismatch_cnt;
  bit     stim_done;

  signed_div_magic_16 dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_divisor      (in_divisor),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_multiplier  (out_multiplier),
    .out_post_shift  (out_post_shift),
    .out_bad_divisor (out_bad_divisor)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Computes the magic multiplier and shift for one divisor.
  function automatic magic_t magic_for(input logic [15:0] d);
    magic_t      r;
    logic        neg;
    logic [15:0] ad, anc, q1, r1, q2, r2, delta;
    logic [16:0] t;
    int          p;
    neg = d[15];
    ad = neg ? 16'(-d) : d;
    r = '0;
    if (ad < 2) begin
      r.bad = 1'b1;
      return r;
    end
    t = 17'h8000 + (neg ? 17'd1 : 17'd0);
    anc = 16'(t - 17'd1 - (t % ad));
    if (anc == 0) anc = 16'd1;
    p = 15;
    q1 = 16'h8000 / anc;
    r1 = 16'(16'h8000 - q1 * anc);
    q2 = 16'h8000 / ad;
    r2 = 16'(16'h8000 - q2 * ad);
    for (int i = 0; i < 16; i++) begin
      p++;
      q1 = q1 << 1;
      r1 = r1 << 1;
      if (r1 >= anc) begin
        q1 = q1 + 16'd1;
        r1 = r1 - anc;
      end
      q2 = q2 << 1;
      r2 = r2 << 1;
      if (r2 >= ad) begin
        q2 = q2 + 16'd1;
        r2 = r2 - ad;
      end
      delta = ad - r2;
      if (!(q1 < delta || (q1 == delta && r1 == 0))) break;
    end
    r.multiplier = q2 + 16'd1;
    if (neg) r.multiplier = -r.multiplier;
    r.post_shift = 4'(p - 16);
    return r;
  endfunction

  // Offers one request and waits for its acceptance.
  task automatic send_divisor(input logic [15:0] d, input bit typed, input magic_t want);
    in_valid   <= 1'b1;
    in_divisor <= d;
    magic_q.push_back(typed ? want : magic_for(d));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_divisor();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 40));
      1: return 16'(-$urandom_range(0, 40));
      2: return 16'(1 << $urandom_range(0, 15));
      3: return 16'(-(1 << $urandom_range(0, 15)));
      default: return 16'($urandom);
    endcase
  endfunction

  dir_row_t dir_rows[] = '{
    '{16'h0000, 1'b1, '{16'h0000, 4'd0, 1'b1}},
    '{16'h0001, 1'b1, '{16'h0000, 4'd0, 1'b1}},
    '{16'hFFFF, 1'b1, '{16'h0000, 4'd0, 1'b1}},
    '{16'h0002, 1'b0, '0},
    '{16'hFFFE, 1'b0, '0},
    '{16'h0003, 1'b0, '0},
    '{16'hFFFD, 1'b0, '0},
    '{16'h0005, 1'b0, '0},
    '{16'h0007, 1'b0, '0},
    '{16'hFFF9, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h8001, 1'b0, '0},
    '{16'h4000, 1'b0, '0},
    '{16'h5555, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0},
    '{16'h00FF, 1'b0, '0},
    '{16'hFF01, 1'b0, '0},
    '{16'h0641, 1'b0, '0}
  };

  // Sender.
  initial begin
    int burst;
    in_valid    = 1'b0;
    in_divisor  = '0;
    rst_n       = 1'b0;
    stim_done   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i])
      send_divisor(dir_rows[i].divisor, dir_rows[i].typed, dir_rows[i].result);
    in_valid <= 1'b0;
    // Wait until the pipeline has fully drained once.
    while (magic_q.size() != 0) @(posedge clk);
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < NumRandom; b++, n++)
        send_divisor(rand_divisor(), 1'b0, '0);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 12));
    end
    in_valid  <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern, with one long hold-off while requests keep coming.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    repeat (300) begin
      @(posedge clk);
      out_ready <= 1'b1;
    end
    repeat (400) @(posedge clk);
    out_ready <= 1'b0;
    repeat (150) @(posedge clk);
    forever begin
      @(posedge clk);
      case ($urandom_range(0, 3))
        0: out_ready <= 1'b0;
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // Result checker.
  initial begin
    magic_t want;
    mismatch_cnt = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (magic_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result %h", out_multiplier);
        end else begin
          want = magic_q.pop_front();
          if (out_multiplier !== want.multiplier || out_post_shift !== want.post_shift ||
              out_bad_divisor !== want.bad) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp m=%h s=%0d bad=%b got m=%h s=%0d bad=%b",
                       want.multiplier, want.post_shift, want.bad,
                       out_multiplier, out_post_shift, out_bad_divisor);
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (magic_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
